FILE: rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the Mandelbrot escape test unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int COORD_W = 32;
  localparam int ITER_W  = 16;
  localparam int Q_DEPTH = 4;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [ITER_W-1:0] ITER_CAP_RESET = 16'd1000;
  localparam logic [APB_AW-1:0] ADDR_ITER_CAP  = 3'd0;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
  } point_t;

  typedef struct packed {
    logic   valid;
    point_t pt;
  } q_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL
  } state_t;

endpackage

FILE: rtl/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Short point queue between the input channel and the iteration engine.
// ----------------------------------------------------------------------------
module mbe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mbe_pkg::point_t   push_pt,
  output logic              full,
  input  logic              pop,
  output mbe_pkg::q_head_t  head
);

  localparam int PTR_W = $clog2(mbe_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(mbe_pkg::Q_DEPTH + 1);

  mbe_pkg::point_t  mem [mbe_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(mbe_pkg::Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.pt    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/mbe_engine.sv
// ----------------------------------------------------------------------------
// mbe_engine
// Iteration engine: z = z*z + c with exact escape test, saturating count of
// escaped points and the result word register.
// ----------------------------------------------------------------------------
module mbe_engine #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mbe_pkg::ITER_W-1:0]      iter_cap,
  input  mbe_pkg::q_head_t                head,
  output logic                            pop,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            escaped,
  output logic [mbe_pkg::COORD_W-1:0]     outside_count
);

  localparam logic signed [63:0] BOUND     = 64'sd2 <<< FRAC_BITS;
  localparam logic signed [63:0] NEG_BOUND = -BOUND;
  localparam logic [64:0]        LIMIT     = 65'd1 << (2 * FRAC_BITS + 2);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  mbe_pkg::state_t state;
  mbe_pkg::state_t state_next;

  logic signed [mbe_pkg::COORD_W-1:0] z_re;
  logic signed [mbe_pkg::COORD_W-1:0] z_im;
  logic signed [mbe_pkg::COORD_W-1:0] c_re;
  logic signed [mbe_pkg::COORD_W-1:0] c_im;
  logic [mbe_pkg::ITER_W-1:0]         iter;
  logic                               first;
  logic signed [63:0]                 p_rr;
  logic signed [63:0]                 p_ii;
  logic signed [63:0]                 p_ri;
  logic [COUNT_WIDTH-1:0]             total;

  logic [64:0]        sq_sum;
  logic               esc_sq;
  logic signed [63:0] nr;
  logic signed [63:0] ni;
  logic               out_bound;
  logic               slot_free;
  logic               fin;
  logic               fin_esc;
  logic               adv;
  logic               fin_go;

  assign sq_sum    = {1'b0, p_rr} + {1'b0, p_ii};
  assign esc_sq    = !first && (sq_sum > LIMIT);
  assign nr        = ((p_rr - p_ii) >>> FRAC_BITS) + $signed({{32{c_re[31]}}, c_re});
  assign ni        = (p_ri >>> (FRAC_BITS - 1)) + $signed({{32{c_im[31]}}, c_im});
  assign out_bound = (nr > BOUND) || (nr < NEG_BOUND) || (ni > BOUND) || (ni < NEG_BOUND);
  assign slot_free = !res_valid || !res_stall;
  assign fin_go    = fin && slot_free;

  always_comb begin
    pop     = 1'b0;
    fin     = 1'b0;
    fin_esc = 1'b0;
    adv     = 1'b0;
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        pop = head.valid;
      end
      mbe_pkg::ST_MUL: begin
      end
      mbe_pkg::ST_EVAL: begin
        priority if (esc_sq) begin
          fin     = 1'b1;
          fin_esc = 1'b1;
        end else if (iter == iter_cap) begin
          fin     = 1'b1;
        end else if (out_bound) begin
          fin     = 1'b1;
          fin_esc = 1'b1;
        end else begin
          adv     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        if (head.valid) begin
          state_next = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        state_next = mbe_pkg::ST_EVAL;
      end
      mbe_pkg::ST_EVAL: begin
        if (adv) begin
          state_next = mbe_pkg::ST_MUL;
        end else if (fin_go) begin
          state_next = mbe_pkg::ST_IDLE;
        end
      end
      default: state_next = mbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbe_pkg::ST_IDLE;
      res_valid <= 1'b0;
      total     <= '0;
    end else begin
      state     <= state_next;
      res_valid <= fin_go || (res_valid && res_stall);
      if (fin_go && fin_esc && (total != COUNT_MAX)) begin
        total <= total + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      c_re  <= head.pt.c_re;
      c_im  <= head.pt.c_im;
      z_re  <= head.pt.c_re;
      z_im  <= head.pt.c_im;
      iter  <= '0;
      first <= 1'b1;
    end else if (adv) begin
      z_re  <= nr[mbe_pkg::COORD_W-1:0];
      z_im  <= ni[mbe_pkg::COORD_W-1:0];
      iter  <= iter + mbe_pkg::ITER_W'(1);
      first <= 1'b0;
    end
    if (state == mbe_pkg::ST_MUL) begin
      p_rr <= z_re * z_re;
      p_ii <= z_im * z_im;
      p_ri <= z_re * z_im;
    end
    if (fin_go) begin
      escaped <= fin_esc;
      if (fin_esc && (total != COUNT_MAX)) begin
        outside_count <= mbe_pkg::COORD_W'(total + COUNT_WIDTH'(1));
      end else begin
        outside_count <= mbe_pkg::COORD_W'(total);
      end
    end
  end

endmodule

FILE: rtl/mandelbrot_escape_test_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_unit
// Mandelbrot escape-time test on Q4.28 points with a running escape count.
// ----------------------------------------------------------------------------
// Points enter on the pt channel (pt_valid, pt_stall, c_re, c_im) and land in
// a four-word queue; pt_stall rises only when that queue is full.
// The engine takes one point at a time and iterates z = z*z + c. Each
// iteration passes through ST_MUL, which forms the three 32x32 products,
// and ST_EVAL, which does the update, bound check and |z|^2 test (the
// squares of the new z are the next iteration's products). A point leaves
// the queue from ST_IDLE and then runs one ST_MUL/ST_EVAL pair per
// iteration until the |z|^2 test, the iter_cap check or an update that
// leaves the +/-2 box ends it in ST_EVAL.
// Results leave on the res channel (res_valid, res_stall, escaped,
// outside_count) from an output register; while res is stalled the engine
// holds its finished point and the queue keeps accepting up to its depth.
// iter_cap is written over the APB port at address 0; the user must write
// it only while the unit is idle, as the block itself does not enforce it.
// Synchronous reset empties the queue and the output, clears the count and
// sets iter_cap to 1000.
// ----------------------------------------------------------------------------
module mandelbrot_escape_test_unit #(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::APB_AW-1:0]         paddr,
  input  logic [mbe_pkg::APB_DW-1:0]         pwdata,
  output logic [mbe_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  input  logic                               pt_valid,
  output logic                               pt_stall,
  input  logic signed [mbe_pkg::COORD_W-1:0] c_re,
  input  logic signed [mbe_pkg::COORD_W-1:0] c_im,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               escaped,
  output logic [mbe_pkg::COORD_W-1:0]        outside_count
);

  logic [mbe_pkg::ITER_W-1:0] iter_cap;
  mbe_pkg::point_t            push_pt;
  mbe_pkg::q_head_t           head;
  logic                       pop;

  assign pready = 1'b1;
  assign prdata = (paddr == mbe_pkg::ADDR_ITER_CAP) ?
                  mbe_pkg::APB_DW'(iter_cap) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cap <= mbe_pkg::ITER_CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == mbe_pkg::ADDR_ITER_CAP)) begin
      iter_cap <= pwdata[mbe_pkg::ITER_W-1:0];
    end
  end

  assign push_pt.c_re = c_re;
  assign push_pt.c_im = c_im;

  mbe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (pt_valid),
    .push_pt (push_pt),
    .full    (pt_stall),
    .pop     (pop),
    .head    (head)
  );

  mbe_engine #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .iter_cap      (iter_cap),
    .head          (head),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .escaped       (escaped),
    .outside_count (outside_count)
  );

endmodule

FILE: rtl/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape test unit, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               pt_valid,
  input logic                               pt_stall,
  input logic signed [mbe_pkg::COORD_W-1:0] c_re,
  input logic signed [mbe_pkg::COORD_W-1:0] c_im,
  input logic                               res_valid,
  input logic                               res_stall,
  input logic                               escaped,
  input logic [mbe_pkg::COORD_W-1:0]        outside_count
);

  logic [mbe_pkg::COORD_W-1:0] last_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (res_valid && !res_stall) begin
      last_count <= outside_count;
    end
  end

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid && !pt_stall)
    else $error("outputs not cleared by reset");

  a_pt_hold: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_stall |=> pt_valid && $stable(c_re) && $stable(c_im))
    else $error("stalled point word changed");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(escaped) && $stable(outside_count))
    else $error("stalled result word changed");

  a_inside_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && !escaped |-> outside_count == last_count)
    else $error("count moved on an inside point");

  a_escape_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && escaped |->
      (outside_count == last_count + mbe_pkg::COORD_W'(1)) || (outside_count == last_count))
    else $error("count did not step on an escaped point");

endmodule

bind mandelbrot_escape_test_unit mbe_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .pt_valid      (pt_valid),
  .pt_stall      (pt_stall),
  .c_re          (c_re),
  .c_im          (c_im),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .escaped       (escaped),
  .outside_count (outside_count)
);
